### src/tidp_pkg.sv
// shared types and constants for the ternary int8 dot product core
package tidp_pkg;

  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned ACT_W     = 8;
  localparam int unsigned PROD_W    = 10;
  localparam int unsigned DELTA_W   = 11;
  localparam int unsigned SUM_W     = 21;
  localparam int unsigned DOT_W     = 22;

  // 2-bit weight codes, weight = code - 1
  localparam logic [1:0] CODE_NEG  = 2'd0;
  localparam logic [1:0] CODE_ZERO = 2'd1;
  localparam logic [1:0] CODE_POS  = 2'd2;
  localparam logic [1:0] CODE_DBL  = 2'd3;

  localparam logic signed [DOT_W-1:0] SUM_MAX = 22'sd1048575;
  localparam logic signed [DOT_W-1:0] SUM_MIN = -22'sd1048576;

  typedef logic signed [ACT_W-1:0]   act_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [DOT_W-1:0]   dot_t;

  typedef struct packed {
    logic fire;
    logic last;
  } acc_ctl_t;

endpackage

### src/tidp_lane.sv
// one lane: decodes a 2-bit weight code and forms its product with an activation
module tidp_lane (
  input  logic [1:0]     code,
  input  tidp_pkg::act_t act,
  output tidp_pkg::prod_t prod
);
  import tidp_pkg::*;

  prod_t act_ext;

  assign act_ext = prod_t'(act);

  always_comb begin
    case (code)
      CODE_NEG:  prod = -act_ext;
      CODE_ZERO: prod = '0;
      CODE_POS:  prod = act_ext;
      CODE_DBL:  prod = act_ext <<< 1;
      default:   prod = '0;
    endcase
  end

endmodule

### src/tidp_merge.sv
// merging stage: adds the lane products into the saturating running sum, and clears the sum after a last item
module tidp_merge (
  input  logic             clk,
  input  logic             rst_n,
  input  tidp_pkg::acc_ctl_t ctl,
  input  tidp_pkg::prod_t  prods [tidp_pkg::NUM_LANES],
  output tidp_pkg::dot_t   result_sum,
  output logic             result_sat
);
  import tidp_pkg::*;

  sum_t   running_sum_r, running_sum_nxt;
  logic   overflow_r, overflow_nxt;
  delta_t delta;
  dot_t   acc_wide;
  dot_t   acc_sat;
  logic   ovf_now;

  always_comb begin
    delta = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      delta = delta + delta_t'(prods[i]);
    end
    acc_wide = dot_t'(running_sum_r) + dot_t'(delta);
    ovf_now  = 1'b0;
    acc_sat  = acc_wide;
    if (acc_wide > SUM_MAX) begin
      acc_sat = SUM_MAX;
      ovf_now = 1'b1;
    end else if (acc_wide < SUM_MIN) begin
      acc_sat = SUM_MIN;
      ovf_now = 1'b1;
    end
  end

  assign result_sum = acc_sat;
  assign result_sat = overflow_r | ovf_now;

  always_comb begin
    running_sum_nxt = running_sum_r;
    overflow_nxt    = overflow_r;
    if (ctl.fire) begin
      if (ctl.last) begin
        running_sum_nxt = '0;
        overflow_nxt    = 1'b0;
      end else begin
        running_sum_nxt = acc_sat[SUM_W-1:0];
        overflow_nxt    = overflow_r | ovf_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r <= '0;
      overflow_r    <= 1'b0;
    end else begin
      running_sum_r <= running_sum_nxt;
      overflow_r    <= overflow_nxt;
    end
  end

endmodule

### src/ternary_int8_dot_product_core.sv
// top level of the ternary weight by int8 activation dot product core
//
// input channel (in_valid/in_ready): one item per cycle, carrying a packed
// byte of four 2-bit weight codes (bits 7:6 pair with in_act_a, down to
// bits 1:0 with in_act_d) and four signed 8-bit activations; code c means
// weight c - 1. in_last_group marks the final item of a vector.
// result channel (out_valid/out_ready): one item per vector, holding the
// saturated 22-bit dot product and a flag set if the sum was clamped at
// any point of the vector.
// throughput: one item per cycle, set by the single accumulator feedback
// in the merging stage. a result is shown once the last item of its vector
// has left the lane stage register and its sum has gone into the output
// register, which takes it only when it is free.
// while a result waits, non-last items keep flowing into the sum; only a
// further last item stalls at the lane stage, and in_ready then drops.
// reset clears the running sum, its overflow flag and all valid bits.
module ternary_int8_dot_product_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_weight_byte,
  input  tidp_pkg::act_t       in_act_a,
  input  tidp_pkg::act_t       in_act_b,
  input  tidp_pkg::act_t       in_act_c,
  input  tidp_pkg::act_t       in_act_d,
  input  logic                 in_last_group,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tidp_pkg::dot_t       out_dot_sum,
  output logic                 out_saturated
);
  import tidp_pkg::*;

  act_t  acts [NUM_LANES];
  prod_t lane_prod [NUM_LANES];

  // lane stage register
  logic  s1_valid_r, s1_valid_nxt;
  logic  s1_last_r;
  prod_t s1_prod_r [NUM_LANES];

  // output register
  logic  out_valid_r, out_valid_nxt;
  dot_t  out_dot_sum_r;
  logic  out_saturated_r;

  logic     in_fire;
  logic     s1_fire;
  logic     out_free;
  acc_ctl_t acc_ctl;
  dot_t     merge_sum;
  logic     merge_sat;

  assign acts[0] = in_act_a;
  assign acts[1] = in_act_b;
  assign acts[2] = in_act_c;
  assign acts[3] = in_act_d;

  // one lane per packed weight code, first code in the top bits
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tidp_lane u_lane (
      .code (in_weight_byte[7-2*g -: 2]),
      .act  (acts[g]),
      .prod (lane_prod[g])
    );
  end

  // output register can take a new result this cycle
  assign out_free = !out_valid_r || out_ready;
  // a non-last item never needs the output register
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign acc_ctl.fire = s1_fire;
  assign acc_ctl.last = s1_last_r;

  tidp_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (acc_ctl),
    .prods      (s1_prod_r),
    .result_sum (merge_sum),
    .result_sat (merge_sat)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_last_r <= in_last_group;
      s1_prod_r <= lane_prod;
    end
    if (s1_fire && s1_last_r) begin
      out_dot_sum_r   <= merge_sum;
      out_saturated_r <= merge_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dot_sum   = out_dot_sum_r;
  assign out_saturated = out_saturated_r;

  // a shown result always lies inside the 21-bit sum range
  a_sum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_dot_sum_r[DOT_W-1] == out_dot_sum_r[DOT_W-2]))
    else $error("result outside accumulator range");

  // the input only stalls behind an occupied lane stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked last item");

  // a last item leaving the lane stage always produces a result
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> out_valid_r)
    else $error("last item produced no result");

  // a non-last item never creates a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !(s1_fire && s1_last_r)) |=> !out_valid_r)
    else $error("result appeared without a last item");

endmodule
